// ===== hw/rtl/awr_pkg.sv =====
// ----------------------------------------------------------------------------
// awr_pkg: shared types and constants of the world-to-relative affine block
// Request and response payload structs, sizes and fixed-point constants.
// ----------------------------------------------------------------------------
package awr_pkg;

   localparam int NUM_BONES = 64;
   localparam int FRAC_BITS = 16;
   localparam int ELEMS = 12;
   localparam int BONE_W = 6;
   localparam int ELEM_W = 4;
   localparam int VAL_W = 32;
   localparam int REST_DEPTH = NUM_BONES * ELEMS;
   localparam int REST_AW = $clog2(REST_DEPTH);

   localparam logic FUNC_REST = 1'b0;
   localparam logic FUNC_WORLD = 1'b1;

   typedef struct packed {
      logic              func;
      logic [BONE_W-1:0] bone;
      logic [ELEM_W-1:0] elem;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [BONE_W-1:0] out_bone;
      logic [ELEM_W-1:0] out_elem;
      logic signed [VAL_W-1:0] out_value;
      logic              singular;
      logic              last;
   } rsp_type;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'(SAT_MAX)) r = 32'sh7FFF_FFFF;
      else if (v < 80'(SAT_MIN)) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // Floor of (v + half) / 2^F.
   function automatic logic signed [79:0] rnd(input logic signed [79:0] v);
      logic signed [79:0] x;
      x = v + (80'sd1 <<< (FRAC_BITS - 1));
      return x >>> FRAC_BITS;
   endfunction

endpackage

// ===== hw/rtl/awr_ram.sv =====
// ----------------------------------------------------------------------------
// awr_ram: generic single-port-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module awr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ===== hw/rtl/affine_world_to_relative_unit.sv =====
// ----------------------------------------------------------------------------
// affine_world_to_relative_unit: world-pose to rest-relative bone affine
// Keeps rest affines per bone in a RAM and emits world * inverse(rest).
// ----------------------------------------------------------------------------
// Rest and world element writes are taken one per cycle while the block is
// idle. A world write to element 11 starts a run. First the twelve rest
// elements of the bone are read from the rest RAM and the world elements
// from the staging RAM. Then a sequencer computes the nine cofactors and the
// determinant. It computes nine quotients on a bit-serial restoring divider.
// The linear products and the translations share one 32x32 multiplier.
// Finally the block presents the twelve results, one per accepted response.
// When the rest determinant is zero the run skips the divider and goes
// straight to the responses. No request is taken during a run.
module affine_world_to_relative_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  awr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output awr_pkg::rsp_type rsp_data
);
   import awr_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_COF = 4'd2,
      S_DET = 4'd3, S_DIV = 4'd4, S_DIVR = 4'd5, S_LIN = 4'd6, S_TRN = 4'd7,
      S_OUT = 4'd8, S_MUL = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;          // element / load / emit index
   logic [3:0] sub_ff, sub_in;          // step inside a dot product
   logic [6:0] dcnt_ff, dcnt_in;        // divider bit counter
   logic [3:0] ret_ff, ret_in;          // state to return to after multiply
   logic [BONE_W-1:0] bone_ff, bone_in;
   logic bvalid_ff, bvalid_in;
   logic sing_ff, sing_in;

   logic signed [31:0] a_ff [ELEMS];   // rest affine of the bone
   logic signed [31:0] w_ff [ELEMS];   // world, translation results in column 3
   logic signed [31:0] cof_ff [9];
   logic signed [31:0] inv_ff [9];
   logic signed [31:0] det_ff;
   logic signed [79:0] acc_ff, acc_in;
   logic signed [31:0] ma_ff, mb_ff;
   logic signed [63:0] prod_ff;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic dneg_ff;

   logic req_fire;
   logic in_ok;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign in_ok = req_data.elem < ELEM_W'(ELEMS);

   // Rest RAM: written by rest requests, read during load.
   logic rest_we;
   logic [REST_AW-1:0] rest_waddr, rest_raddr;
   logic [31:0] rest_rdata, world_rdata;
   logic [BONE_W+ELEM_W-1:0] rest_wfull, rest_rfull;
   assign rest_wfull = req_data.bone * ELEM_W'(ELEMS) + req_data.elem;
   assign rest_waddr = rest_wfull[REST_AW-1:0];
   assign rest_we = req_fire && in_ok && req_data.func == FUNC_REST &&
      {1'b0, req_data.bone} < (BONE_W+1)'(NUM_BONES);
   assign rest_rfull = bone_ff * ELEM_W'(ELEMS) + cnt_ff;
   assign rest_raddr = rest_rfull[REST_AW-1:0];

   awr_ram #(.WIDTH(32), .DEPTH(REST_DEPTH)) u_rest (
      .clock(clock), .we(rest_we), .waddr(rest_waddr), .wdata(req_data.value),
      .raddr(rest_raddr), .rdata(rest_rdata));

   logic world_we;
   assign world_we = req_fire && in_ok && req_data.func == FUNC_WORLD;
   awr_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_world (
      .clock(clock), .we(world_we), .waddr(req_data.elem), .wdata(req_data.value),
      .raddr(cnt_ff), .rdata(world_rdata));

   // Index helpers for the cofactor and dot product sequencing.
   function automatic logic [1:0] nx(input logic [1:0] i, input logic [1:0] k);
      logic [2:0] s;
      s = {1'b0, i} + {1'b0, k};
      return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // Row and column of a 3x3 index 0..8.
   logic [1:0] cr, cc;
   logic [3:0] cidx;
   assign cr = (cnt_ff >= 4'd6) ? 2'd2 : (cnt_ff >= 4'd3) ? 2'd1 : 2'd0;
   assign cc = 2'(cnt_ff - {1'b0, cr, 1'b0} - {2'b00, cr});
   assign cidx = {2'b00, cr} * 4'd3 + {2'b00, cc};

   // Operand choice for the shared multiplier: sub_ff 0/1 select the cofactor
   // cross products, 0..2 select dot product terms.
   logic signed [31:0] opa, opb;
   logic [1:0] sk;
   assign sk = sub_ff[1:0];
   always_comb begin
      opa = '0;
      opb = '0;
      case (ret_ff)
         S_COF: begin
            if (sub_ff == 4'd0) begin
               opa = a_ff[4*nx(cr,2'd1) + nx(cc,2'd1)];
               opb = a_ff[4*nx(cr,2'd2) + nx(cc,2'd2)];
            end else begin
               opa = a_ff[4*nx(cr,2'd1) + nx(cc,2'd2)];
               opb = a_ff[4*nx(cr,2'd2) + nx(cc,2'd1)];
            end
         end
         S_DET: begin
            opa = a_ff[sk];
            opb = cof_ff[sk];
         end
         S_LIN: begin
            opa = w_ff[4*cr + sk];
            opb = inv_ff[3*sk + cc];
         end
         S_TRN: begin
            opa = a_ff[4*cnt_ff[1:0] + sk];  // replaced by the M row below
            opb = a_ff[4*sk + 3];
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // Linear results are kept in m_ff so rest t0 stays available.
   logic signed [31:0] m_ff [9];

   logic signed [31:0] topa;
   assign topa = m_ff[3*cnt_ff[1:0] + sk];

   logic signed [31:0] res_val;
   always_comb begin
      if (sing_ff) res_val = '0;
      else if (cnt_ff[1:0] == 2'd3) res_val = w_ff[cnt_ff];
      else res_val = m_ff[3*cnt_ff[3:2] + cnt_ff[1:0]];
   end

   // Divider operands for quotient cnt_ff: inv[i][j] = C[j][i] / det.
   logic signed [31:0] dnum;
   logic [63:0] unum, uden;
   logic signed [63:0] snum;
   assign dnum = cof_ff[3*cc + cr];
   assign snum = 64'(dnum) <<< FRAC_BITS;
   assign unum = snum[63] ? 64'(-snum) : snum;
   assign uden = det_ff[31] ? 64'(-64'(det_ff)) : 64'(det_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      sub_in = sub_ff;
      dcnt_in = dcnt_ff;
      ret_in = ret_ff;
      bone_in = bone_ff;
      bvalid_in = bvalid_ff;
      sing_in = sing_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      case (state_ff)
         S_IDLE: begin
            if (world_we && req_data.elem == ELEM_W'(ELEMS - 1)) begin
               state_in = S_LOAD;
               cnt_in = '0;
               sub_in = '0;
               bone_in = req_data.bone;
               bvalid_in = {1'b0, req_data.bone} < (BONE_W+1)'(NUM_BONES);
            end
         end
         S_LOAD: begin
            sub_in = 4'd1;
            if (sub_ff != 4'd0) cnt_in = cnt_ff + 4'd1;
            if (sub_ff != 4'd0 && cnt_ff == 4'(ELEMS)) begin
               state_in = S_MUL;
               ret_in = S_COF;
               cnt_in = '0;
               sub_in = '0;
               acc_in = '0;
            end
         end
         S_MUL: state_in = S_COF;     // product register settles
         S_COF: begin
            case (ret_ff)
               S_COF: begin
                  if (sub_ff == 4'd0) begin
                     acc_in = 80'(prod_ff);
                     sub_in = 4'd1;
                     state_in = S_MUL;
                  end else begin
                     sub_in = '0;
                     acc_in = '0;
                     state_in = S_MUL;
                     if (cnt_ff == 4'd8) begin
                        ret_in = S_DET;
                        cnt_in = '0;
                     end else cnt_in = cnt_ff + 4'd1;
                  end
               end
               default: begin
                  // dot product term: add rounded saturated product
                  acc_in = acc_ff + 80'(sat32(rnd(80'(prod_ff))));
                  if (sub_ff != 4'd2) begin
                     sub_in = sub_ff + 4'd1;
                     state_in = S_MUL;
                  end else begin
                     sub_in = '0;
                     state_in = ret_ff;
                  end
               end
            endcase
         end
         S_DET: begin
            sing_in = (sat32(acc_ff) == 32'sd0);
            if (sat32(acc_ff) == 32'sd0) begin
               state_in = S_OUT;
               cnt_in = '0;
            end else begin
               state_in = S_DIV;
               cnt_in = '0;
            end
         end
         S_DIV: begin
            // dividend is |n| + |d|/2 so the quotient rounds half away from zero
            rem_in = '0;
            quo_in = unum + (uden >> 1);
            dcnt_in = '0;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            // restoring division, one quotient bit per cycle
            if (dcnt_ff != 7'd64) begin
               logic [64:0] t;
               t = {rem_ff, quo_ff[63]};
               if (t >= {1'b0, den_ff}) begin
                  rem_in = 64'(t - {1'b0, den_ff});
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = t[63:0];
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               dcnt_in = dcnt_ff + 7'd1;
            end else begin
               if (cnt_ff == 4'd8) begin
                  cnt_in = '0;
                  sub_in = '0;
                  acc_in = '0;
                  ret_in = S_LIN;
                  state_in = S_MUL;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
                  state_in = S_DIV;
               end
            end
         end
         S_LIN: begin
            acc_in = '0;
            sub_in = '0;
            state_in = S_MUL;
            if (cnt_ff == 4'd8) begin
               cnt_in = '0;
               ret_in = S_TRN;
            end else cnt_in = cnt_ff + 4'd1;
         end
         S_TRN: begin
            acc_in = '0;
            sub_in = '0;
            if (cnt_ff == 4'd2) begin
               cnt_in = '0;
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (cnt_ff == 4'(ELEMS - 1)) begin
                  cnt_in = '0;
                  state_in = S_IDLE;
               end else cnt_in = cnt_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // The translation dot product uses M rows; redirect operands there.
   logic signed [31:0] mul_a;
   assign mul_a = (ret_ff == S_TRN) ? topa : opa;

   logic [63:0] q_r;
   assign q_r = quo_ff;  // division of (|n| + |d|/2) by |d|

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         sub_ff <= '0;
         dcnt_ff <= '0;
         ret_ff <= S_COF;
         sing_ff <= 1'b0;
         bvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
         dcnt_ff <= dcnt_in;
         ret_ff <= ret_in;
         sing_ff <= sing_in;
         bvalid_ff <= bvalid_in;
      end
      bone_ff <= bone_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      prod_ff <= mul_a * opb;
      if (state_ff == S_LOAD && sub_ff != 4'd0 && cnt_ff != 4'd0) begin
         a_ff[cnt_ff - 4'd1] <= bvalid_ff ? rest_rdata : 32'sd0;
         w_ff[cnt_ff - 4'd1] <= world_rdata;
      end
      if (state_ff == S_COF && ret_ff == S_COF && sub_ff != 4'd0)
         cof_ff[cidx] <= sat32(rnd(acc_ff - 80'(prod_ff)));
      if (state_ff == S_DET) det_ff <= sat32(acc_ff);
      if (state_ff == S_DIV) begin
         den_ff <= uden;
         dneg_ff <= snum[63] != det_ff[31];
      end
      if (state_ff == S_DIVR && dcnt_ff == 7'd64) begin
         logic [63:0] qc;
         qc = (q_r > 64'h8000_0000) ? 64'h8000_0000 : q_r;
         inv_ff[cnt_ff] <= dneg_ff ? sat32(-80'(qc)) : sat32(80'(qc));
      end
      if (state_ff == S_LIN) m_ff[cidx] <= sat32(acc_ff);
      if (state_ff == S_TRN)
         w_ff[4*cnt_ff[1:0] + 3] <= sat32(80'(w_ff[4*cnt_ff[1:0] + 3]) - 80'(sat32(acc_ff)));
   end

   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.out_bone = bone_ff;
   assign rsp_data.out_elem = cnt_ff;
   assign rsp_data.out_value = res_val;
   assign rsp_data.singular = sing_ff;
   assign rsp_data.last = (cnt_ff == 4'(ELEMS - 1));
endmodule

// ===== hw/rtl/awr_checker.sv =====
// ----------------------------------------------------------------------------
// awr_checker: port-level checks of the world-to-relative affine unit
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module awr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input awr_pkg::rsp_type rsp_data
);
   import awr_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid) else $error("request withdrawn");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during a run");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.out_elem == ELEM_W'(ELEMS - 1))))
      else $error("last flag mismatch");

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> rsp_data.out_value == '0)
      else $error("singular result not zero");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid && rsp_data.out_elem == $past(rsp_data.out_elem) + 4'd1)
      else $error("response order broken");
endmodule

bind affine_world_to_relative_unit awr_checker u_awr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
